[sv/pcs_pkg.sv]
// shared types, constants and the gap shrink function for the pixel run sorter
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

  localparam int PIX_W     = 32;
  localparam int RG_W      = 16;
  localparam int KEY_W     = 24;
  localparam int GAP_W     = 7;
  localparam int GAP_MUL   = 821;
  localparam int GAP_SHIFT = 10;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS,
    ST_CHECK,
    ST_RD,
    ST_MUL,
    ST_CMP,
    ST_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } pcs_state_t;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic idx_clr;
    logic mul;
    logic cmp;
    logic wr_lo;
    logic step;
    logic emit_ld;
    logic run_done;
  } pcs_cmd_t;

  typedef struct packed {
    logic run_close;
    logic more_pass;
    logic in_range;
    logic is_less;
    logic emit_last;
  } pcs_stat_t;

  // floor(g / 1.247330950103979), exact for every gap up to 115
  function automatic logic [GAP_W-1:0] shrink_gap(input logic [GAP_W-1:0] g);
    logic [GAP_W+GAP_SHIFT-1:0] prod;
    prod = (GAP_W+GAP_SHIFT)'(g) * (GAP_W+GAP_SHIFT)'(GAP_MUL);
    return prod[GAP_SHIFT +: GAP_W];
  endfunction

endpackage
`default_nettype wire

[sv/pcs_channels.sv]
// valid/ready channel interfaces for input pixels and sorted result pixels
`timescale 1ns / 1ps
`default_nettype none
interface pcs_in_if;
  import pcs_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_in;
  logic   last_in;

  modport source (output valid, output pixel_in, output last_in, input ready);
  modport sink (input valid, input pixel_in, input last_in, output ready);
  modport monitor (input valid, input ready, input pixel_in, input last_in);
endinterface

interface pcs_out_if;
  import pcs_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   last_out;

  modport source (output valid, output pixel_out, output last_out, input ready);
  modport sink (input valid, input pixel_out, input last_out, output ready);
  modport monitor (input valid, input ready, input pixel_out, input last_out);
endinterface
`default_nettype wire

[sv/pcs_ram.sv]
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module pcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule
`default_nettype wire

[sv/pcs_ctrl.sv]
// sequencer for load, comb sort passes and emit of one pixel run
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire pcs_pkg::pcs_stat_t  stat,
  output pcs_pkg::pcs_cmd_t        cmd
);
  import pcs_pkg::*;

  pcs_state_t state_r;
  pcs_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && stat.run_close) state_nxt = ST_PASS;
      end
      ST_PASS: begin
        state_nxt = stat.more_pass ? ST_CHECK : ST_EMIT_RD;
      end
      ST_CHECK: begin
        state_nxt = stat.in_range ? ST_RD : ST_PASS;
      end
      ST_RD:      state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_CMP;
      ST_CMP: begin
        state_nxt = stat.is_less ? ST_WR : ST_CHECK;
      end
      ST_WR:      state_nxt = ST_CHECK;
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_ready) state_nxt = stat.emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PASS: begin
        cmd.idx_clr    = 1'b1;
        cmd.pass_start = stat.more_pass;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_CMP: begin
        cmd.cmp  = 1'b1;
        cmd.step = !stat.is_less;
      end
      ST_WR: begin
        cmd.wr_lo = 1'b1;
        cmd.step  = 1'b1;
      end
      ST_EMIT_LD: cmd.emit_ld = 1'b1;
      ST_EMIT_WAIT: begin
        out_valid    = 1'b1;
        cmd.run_done = out_ready && stat.emit_last;
        cmd.step     = out_ready && !stat.emit_last;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/pcs_datapath.sv]
// run store, counters, key multipliers and compare for the comb sort
`timescale 1ns / 1ps
`default_nettype none
module pcs_datapath #(
  parameter int MAX_RUN = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pcs_pkg::pcs_cmd_t  cmd,
  input  wire pcs_pkg::pixel_t    in_pixel,
  input  wire logic               in_last,
  output pcs_pkg::pcs_stat_t      stat,
  output pcs_pkg::pixel_t         out_pixel,
  output logic                    out_last
);
  import pcs_pkg::*;

  localparam int AW = $clog2(MAX_RUN);
  localparam int CW = $clog2(MAX_RUN + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] gap_r, gap_nxt;
  logic          swap_r, swap_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  pixel_t          lo_px_r, hi_px_r;
  logic [RG_W-1:0] lo_rg_r, hi_rg_r;
  pixel_t          out_pixel_r;
  logic            out_last_r;

  logic [CW:0]      hi_sum;
  logic [AW-1:0]    hi_addr;
  logic [CW-1:0]    count_inc;
  logic             run_close;
  logic             is_less;
  logic [KEY_W-1:0] lo_key, hi_key;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  pixel_t           ram_wdata;
  pixel_t           rd_a, rd_b;

  assign hi_sum    = (CW+1)'(idx_r) + (CW+1)'(gap_r);
  assign hi_addr   = hi_sum[AW-1:0];
  assign count_inc = count_r + CW'(1);
  assign run_close = in_last || (count_inc == CW'(MAX_RUN));

  assign lo_key  = KEY_W'(lo_rg_r) * KEY_W'(lo_px_r[7:0]);
  assign hi_key  = KEY_W'(hi_rg_r) * KEY_W'(hi_px_r[7:0]);
  assign is_less = hi_key < lo_key;

  assign stat.run_close = run_close;
  assign stat.more_pass = (gap_r > CW'(1)) || swap_r;
  assign stat.in_range  = hi_sum < (CW+1)'(count_r);
  assign stat.is_less   = is_less;
  assign stat.emit_last = ((CW+1)'(idx_r) + (CW+1)'(1)) == (CW+1)'(count_r);

  always_comb begin
    count_nxt = count_r;
    gap_nxt   = gap_r;
    swap_nxt  = swap_r;
    idx_nxt   = idx_r;
    if (cmd.run_done) begin
      count_nxt = '0;
    end else if (cmd.load) begin
      count_nxt = count_inc;
    end
    if (cmd.load && run_close) begin
      gap_nxt  = count_inc;
      swap_nxt = 1'b0;
    end else if (cmd.pass_start) begin
      if (gap_r > CW'(1)) gap_nxt = CW'(shrink_gap(GAP_W'(gap_r)));
      swap_nxt = 1'b0;
    end else if (cmd.cmp && is_less) begin
      swap_nxt = 1'b1;
    end
    if (cmd.idx_clr || cmd.run_done) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      gap_r   <= '0;
      swap_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      gap_r   <= gap_nxt;
      swap_r  <= swap_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      lo_px_r <= rd_a;
      hi_px_r <= rd_b;
      lo_rg_r <= RG_W'(rd_a[23:16]) * RG_W'(rd_a[15:8]);
      hi_rg_r <= RG_W'(rd_b[23:16]) * RG_W'(rd_b[15:8]);
    end
    if (cmd.emit_ld) begin
      out_pixel_r <= rd_a;
      out_last_r  <= stat.emit_last;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = hi_px_r;
    if (cmd.load) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = in_pixel;
    end else if (cmd.cmp && is_less) begin
      ram_we    = 1'b1;
      ram_waddr = hi_addr;
      ram_wdata = lo_px_r;
    end else if (cmd.wr_lo) begin
      ram_we    = 1'b1;
    end
  end

  pcs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_RUN)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (idx_r),
    .rdata_a (rd_a),
    .raddr_b (hi_addr),
    .rdata_b (rd_b)
  );

  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

[sv/pixel_run_comb_sorter.sv]
// top level: collects a pixel run, comb sorts it by r*g*b and emits it
// load: one cycle per item while the run is open
// sort: per pass PASS and CHECK, per compare CHECK, RD, MUL and CMP plus WR when it swaps (two-read store)
// emit: per result EMIT_RD, EMIT_LD, then EMIT_WAIT until out ready, after the last pass
// reset clears the sequencer and the count, gap, swap and index registers
// the run store is not cleared; only entries of the current run are read
`timescale 1ns / 1ps
`default_nettype none
module pixel_run_comb_sorter #(
  parameter int MAX_RUN = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pcs_in_if.sink     in_ch,
  pcs_out_if.source  out_ch
);
  import pcs_pkg::*;

  pcs_cmd_t  cmd;
  pcs_stat_t stat;

  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcs_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_pixel  (in_ch.pixel_in),
    .in_last   (in_ch.last_in),
    .stat      (stat),
    .out_pixel (out_ch.pixel_out),
    .out_last  (out_ch.last_out)
  );

endmodule
`default_nettype wire

[sv/pcs_checker.sv]
// port level assertions for the pixel run sorter and their bind
`timescale 1ns / 1ps
`default_nettype none
module pcs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_last,
  input wire logic [31:0] out_pixel
);

  // no item taken in while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_last))
    else $error("stalled result changed");

  a_close_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after last item");

  a_reopen_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("input not reopened after final result");

endmodule

bind pixel_run_comb_sorter pcs_checker u_pcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_in),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_out),
  .out_pixel (out_ch.pixel_out)
);
`default_nettype wire
